// File: rtl/sbd_pkg.sv
// Shared types, constants and the CRC-16 byte step for the servo-bus deframer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sbd_pkg;

  // Longest raw payload that a packet may carry before it is flagged.
  localparam int unsigned MAX_PAYLOAD = 1024;

  // Depth of the queue between the byte classifier and the packet engine.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Framing bytes, CRC polynomial and the status instruction reset value.
  localparam logic [7:0]  BYTE_FF     = 8'hFF;
  localparam logic [7:0]  BYTE_FD     = 8'hFD;
  localparam logic [7:0]  BYTE_00     = 8'h00;
  localparam logic [23:0] MARKER      = 24'hFFFFFD;
  localparam logic [15:0] CRC_POLY    = 16'h8005;
  localparam logic [7:0]  STATUS_INIT = 8'd85;

  // Packet engine phases.
  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_FIELDS = 3'd1,
    PH_ERROR  = 3'd2,
    PH_DATA   = 3'd3,
    PH_CHECK  = 3'd4
  } phase_t;

  // Result kinds carried on the output user field.
  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_OK       = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  // Header and body field positions inside the fields phase.
  localparam logic [1:0] FLD_ID    = 2'd0;
  localparam logic [1:0] FLD_LEN_L = 2'd1;
  localparam logic [1:0] FLD_LEN_H = 2'd2;
  localparam logic [1:0] FLD_INSTR = 2'd3;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    logic [7:0] data;
    logic       after_marker;
  } rx_entry_t;

  // CRC-16, MSB first, one byte folded in.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC after the header FF FF FD 00, starting from zero.
  localparam logic [15:0] CRC_SEED =
    crc_byte(crc_byte(crc_byte(crc_byte(16'h0000, BYTE_FF), BYTE_FF), BYTE_FD), BYTE_00);

endpackage

`default_nettype wire

// File: rtl/sbd_front.sv
// Input side of the deframer: accepts raw bytes and tags each with whether it
// follows the FF FF FD marker. Depends on sbd_pkg.
`default_nettype none

module sbd_front
  import sbd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic [7:0] in_data,
  output logic           push,
  output rx_entry_t      push_entry,
  input  wire logic      queue_full
);

  // Three most recent bytes, newest in the low byte.
  logic [23:0] recent_bytes;

  assign in_ready = !queue_full && !rst;
  assign push     = in_valid && in_ready;

  // Classification of the byte entering now.
  always_comb begin
    push_entry.data         = in_data;
    push_entry.after_marker = (recent_bytes == MARKER);
  end

  // Every accepted byte shifts into the history.
  always_ff @(posedge clk) begin
    if (rst) begin
      recent_bytes <= '0;
    end else if (push) begin
      recent_bytes <= {recent_bytes[15:0], in_data};
    end
  end

endmodule

`default_nettype wire

// File: rtl/sbd_queue.sv
// Short FIFO that decouples the byte classifier from the packet engine.
// Depends on sbd_pkg for the entry type and depth.
`default_nettype none

module sbd_queue
  import sbd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire rx_entry_t push_entry,
  output logic           full,
  output logic           pop_valid,
  input  wire logic      pop,
  output rx_entry_t      pop_entry
);

  rx_entry_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_entry = mem[rd_ptr];

  // Storage is written at the tail; no reset needed for payload.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/sbd_back.sv
// Packet engine: walks the frame fields, keeps the running CRC and holds the
// result in an output register. Depends on sbd_pkg.
`default_nettype none

module sbd_back
  import sbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  wire rx_entry_t   q_entry,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [63:0]      out_data
);

  logic [7:0]  status_instruction;

  phase_t      phase, phase_next;
  logic [15:0] crc_acc, crc_next;
  logic [1:0]  field_count, field_count_next;
  logic [7:0]  length_low, length_low_next;
  logic [7:0]  packet_id, packet_id_next;
  logic [7:0]  packet_instruction, packet_instruction_next;
  logic [7:0]  packet_error, packet_error_next;
  logic [15:0] raw_remaining, raw_remaining_next;
  logic [7:0]  checksum_low, checksum_low_next;

  logic        emit;
  kind_t       emit_kind;
  logic [7:0]  emit_data;
  logic [15:0] emit_rx;

  logic [7:0]  b;
  logic        stuffing;
  logic [15:0] crc_fed;
  logic [15:0] rx_word;
  logic [15:0] full_len;
  logic        is_status;
  logic [15:0] over;
  logic [15:0] payload_len;
  logic [15:0] rem_dec;

  assign cfg_ready = !rst;

  // Take a byte whenever the output register is free or being emptied.
  assign q_pop = q_valid && (!out_valid || out_ready);

  // Register written from the configuration channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      status_instruction <= STATUS_INIT;
    end else if (cfg_valid && cfg_ready) begin
      status_instruction <= cfg_data;
    end
  end

  assign b           = q_entry.data;
  assign stuffing    = (b == BYTE_FD) && q_entry.after_marker;
  assign crc_fed     = crc_byte(crc_acc, b);
  assign rx_word     = {b, checksum_low};
  assign full_len    = {b, length_low};
  assign is_status   = (b == status_instruction);
  assign over        = is_status ? 16'd4 : 16'd3;
  assign payload_len = raw_remaining - over;
  assign rem_dec     = raw_remaining - 16'd1;

  // Next state of the frame walker for the byte at the queue head.
  always_comb begin
    phase_next              = phase;
    crc_next                = crc_acc;
    field_count_next        = field_count;
    length_low_next         = length_low;
    packet_id_next          = packet_id;
    packet_instruction_next = packet_instruction;
    packet_error_next       = packet_error;
    raw_remaining_next      = raw_remaining;
    checksum_low_next       = checksum_low;
    emit                    = 1'b0;
    emit_kind               = KIND_DATA;
    emit_data               = 8'h00;
    emit_rx                 = 16'h0000;
    unique case (phase)
      PH_FIELDS: begin
        crc_next = crc_fed;
        if (!stuffing) begin
          unique case (field_count)
            FLD_ID: begin
              packet_id_next   = b;
              field_count_next = FLD_LEN_L;
            end
            FLD_LEN_L: begin
              length_low_next  = b;
              field_count_next = FLD_LEN_H;
            end
            FLD_LEN_H: begin
              raw_remaining_next = full_len;
              field_count_next   = FLD_INSTR;
            end
            default: begin
              packet_instruction_next = b;
              field_count_next        = FLD_ID;
              if (raw_remaining < over) begin
                // Length field too small for the fixed fields.
                phase_next = PH_HUNT;
                emit       = 1'b1;
                emit_kind  = KIND_OVERFLOW;
              end else begin
                raw_remaining_next = payload_len;
                if (is_status) begin
                  phase_next = PH_ERROR;
                end else if (payload_len > 16'(MAX_PAYLOAD)) begin
                  phase_next = PH_HUNT;
                  emit       = 1'b1;
                  emit_kind  = KIND_OVERFLOW;
                end else begin
                  phase_next = (payload_len == '0) ? PH_CHECK : PH_DATA;
                end
              end
            end
          endcase
        end
      end
      PH_ERROR: begin
        crc_next = crc_fed;
        if (!stuffing) begin
          packet_error_next = b;
          if (raw_remaining > 16'(MAX_PAYLOAD)) begin
            phase_next = PH_HUNT;
            emit       = 1'b1;
            emit_kind  = KIND_OVERFLOW;
          end else begin
            field_count_next = FLD_ID;
            phase_next       = (raw_remaining == '0) ? PH_CHECK : PH_DATA;
          end
        end
      end
      PH_DATA: begin
        crc_next           = crc_fed;
        raw_remaining_next = rem_dec;
        if (rem_dec == '0) begin
          field_count_next = FLD_ID;
          phase_next       = PH_CHECK;
        end
        if (!stuffing) begin
          emit      = 1'b1;
          emit_kind = KIND_DATA;
          emit_data = b;
        end
      end
      PH_CHECK: begin
        if (field_count == FLD_ID) begin
          checksum_low_next = b;
          field_count_next  = FLD_LEN_L;
        end else begin
          field_count_next = FLD_ID;
          phase_next       = PH_HUNT;
          emit             = 1'b1;
          emit_kind        = (rx_word == crc_acc) ? KIND_OK : KIND_MISMATCH;
          emit_rx          = rx_word;
        end
      end
      default: begin
        phase_next = PH_HUNT;
        if ((b == BYTE_00) && q_entry.after_marker) begin
          crc_next          = CRC_SEED;
          packet_error_next = 8'h00;
          field_count_next  = FLD_ID;
          phase_next        = PH_FIELDS;
        end
      end
    endcase
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HUNT;
      crc_acc            <= '0;
      field_count        <= '0;
      length_low         <= '0;
      packet_id          <= '0;
      packet_instruction <= '0;
      packet_error       <= '0;
      raw_remaining      <= '0;
      checksum_low       <= '0;
    end else if (q_pop) begin
      phase              <= phase_next;
      crc_acc            <= crc_next;
      field_count        <= field_count_next;
      length_low         <= length_low_next;
      packet_id          <= packet_id_next;
      packet_instruction <= packet_instruction_next;
      packet_error       <= packet_error_next;
      raw_remaining      <= raw_remaining_next;
      checksum_low       <= checksum_low_next;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload, loaded with the post-byte packet fields.
  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_kind <= emit_kind;
      out_data <= {crc_next, emit_rx, packet_error_next, packet_instruction_next,
                   packet_id_next, emit_data};
    end
  end

  // A payload phase always has bytes left to take.
  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> raw_remaining != '0)
    else $error("payload phase with no bytes remaining");

  // The payload count never exceeds the limit once the payload starts.
  a_data_bounded: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA || phase == PH_CHECK) |-> raw_remaining <= 16'(MAX_PAYLOAD))
    else $error("payload count above limit");

  // A checksum verdict always returns the engine to the hunt.
  a_verdict_hunt: assert property (@(posedge clk) disable iff (rst)
    (q_pop && emit && (emit_kind == KIND_OK || emit_kind == KIND_MISMATCH))
      |=> phase == PH_HUNT)
    else $error("checksum verdict did not restart the hunt");

  // No byte is consumed while a result is stuck in the output register.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> !$past(q_pop))
    else $error("byte consumed while output stalled");

endmodule

`default_nettype wire

// File: rtl/servo_bus_packet_deframer.sv
// Top level of the servo-bus packet deframer: classifier, queue and engine.
// Depends on sbd_pkg, sbd_front, sbd_queue and sbd_back.
//
// The block takes one received byte per transaction on the slave stream and
// sustains one byte per clock cycle: the engine folds a byte into its CRC-16
// (poly 0x8005, zero start) with a combinational byte step, so nothing but
// output back-pressure slows it. A byte is written into the four-entry queue
// at the edge that accepts it; the engine loads its result into the result
// register when it pops the byte, which it holds off while an unaccepted
// result sits there. Each byte yields at most one result: a payload byte,
// packet ok, checksum mismatch or length overflow. Bytes that form the header
// FF FF FD 00 or stuffing bytes produce no result. The status instruction
// register may be written at any time the block is idle and applies from the
// next instruction byte on.
`default_nettype none

module servo_bus_packet_deframer
  import sbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: status_instruction.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  // Input bytes.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  // Results.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [7:0] data_byte, [15:8] node id,
                                           // [23:16] instruction, [31:24] error_code,
                                           // [47:32] received_crc, [63:48] computed_crc
  output logic [1:0]       m_axis_tuser    // [1:0] kind
);

  logic      push;
  rx_entry_t push_entry;
  logic      queue_full;
  logic      q_valid;
  logic      q_pop;
  rx_entry_t q_entry;

  // Byte classifier.
  sbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  // Decoupling queue.
  sbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_entry  (q_entry)
  );

  // Packet engine and result register.
  sbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_entry   (q_entry),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire
